### design/ray_box_slab_test_core_macros.svh
// Assertion macros used by the ray/box slab test checker.
`ifndef RAY_BOX_SLAB_TEST_CORE_MACROS_SVH
`define RAY_BOX_SLAB_TEST_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define RBST_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("rbst assertion failed");

// next-cycle implication, checked out of reset
`define RBST_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("rbst assertion failed");

`endif

### design/rbst_pkg.sv
// Shared types and constants for the ray/box slab test core.
`timescale 1ns / 1ps

package rbst_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int HIT_EPSILON_DEF = 7;
    localparam int DIFF_W          = 34;
    localparam int QDEPTH          = 2;

    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    typedef enum logic [2:0] {
        REG_MIN_X = 3'd0,
        REG_MIN_Y = 3'd1,
        REG_MIN_Z = 3'd2,
        REG_EXT_X = 3'd3,
        REG_EXT_Y = 3'd4,
        REG_EXT_Z = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [2:0][31:0] mn;
        logic [2:0][30:0] ext;
    } box_t;

    // one axis of a classified ray
    typedef struct packed {
        logic signed [DIFF_W-1:0] lo;
        logic signed [DIFF_W-1:0] hi;
        logic                     dneg;
        logic [31:0]              dmag;
        logic                     dzero;
        logic                     in_slab;
    } axis_t;

    typedef struct packed {
        axis_t [2:0] ax;
    } item_t;

endpackage

### design/rbst_front.sv
// Front end: slab distances and direction classification per axis.
`timescale 1ns / 1ps

module rbst_front
(
    input  logic                 s_tvalid,
    input  logic [191:0]         s_tdata,
    input  rbst_pkg::box_t       box,
    output logic                 push,
    output rbst_pkg::item_t      item
);

    always_comb
    begin
        logic signed [rbst_pkg::DIFF_W-1:0] mn;
        logic signed [rbst_pkg::DIFF_W-1:0] org;
        logic [31:0]                        d;
        for (int a = 0; a < 3; a++)
        begin
            mn  = rbst_pkg::DIFF_W'($signed(box.mn[a]));
            org = rbst_pkg::DIFF_W'($signed(s_tdata[32*a +: 32]));
            d   = s_tdata[96 + 32*a +: 32];
            item.ax[a].lo      = mn - org;
            item.ax[a].hi      = mn + $signed({3'b000, box.ext[a]}) - org;
            item.ax[a].dneg    = d[31];
            item.ax[a].dmag    = d[31] ? (~d + 32'd1) : d;
            item.ax[a].dzero   = (d == 32'd0);
            item.ax[a].in_slab = (item.ax[a].lo <= 0) && (item.ax[a].hi >= 0);
        end
    end

    assign push = s_tvalid;

endmodule

### design/rbst_queue.sv
// Two-entry queue between the front end and the datapath.
`timescale 1ns / 1ps

module rbst_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rbst_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output rbst_pkg::item_t head_item
);

    rbst_pkg::item_t mem_reg [rbst_pkg::QDEPTH];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;
    logic            do_push, do_pop;

    assign full       = (count_reg == 2'(rbst_pkg::QDEPTH));
    assign head_valid = (count_reg != 2'd0);
    assign head_item  = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### design/rbst_back.sv
// Datapath: pipelined reciprocal, slab products, saturation and min/max.
`timescale 1ns / 1ps

module rbst_back
#(
    parameter int FRAC_BITS   = rbst_pkg::FRAC_BITS_DEF,
    parameter int HIT_EPSILON = rbst_pkg::HIT_EPSILON_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  rbst_pkg::item_t in_item,
    output logic            pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [71:0]     m_tdata
);

    localparam int QW = 2*FRAC_BITS + 1;

    logic en;

    // divider: one quotient bit of 2^(2F)/|d| per stage
    logic            dv_vld_reg  [QW];
    rbst_pkg::item_t dv_item_reg [QW];
    logic [31:0]     dv_rem_reg  [QW][3];
    logic [QW-1:0]   dv_q_reg    [QW][3];
    logic [31:0]     dv_rem_next [QW][3];
    logic [QW-1:0]   dv_q_next   [QW][3];

    logic [63:0]     mu_prod_reg [3][2], mu_prod_next [3][2];
    logic            mu_neg_reg  [3][2], mu_neg_next  [3][2];
    logic            mu_dz_reg   [3],    mu_in_reg    [3];
    logic            mu_vld_reg;

    logic signed [31:0] sl_en_reg [3], sl_en_next [3];
    logic signed [31:0] sl_ex_reg [3], sl_ex_next [3];
    logic               sl_vld_reg;

    logic               out_vld_reg;
    logic               out_hit_reg, out_hit_next;
    logic signed [31:0] out_t0_reg, out_t0_next;
    logic signed [31:0] out_t1_reg, out_t1_next;

    assign en  = m_tready || !out_vld_reg;
    assign pop = en && in_valid;

    always_comb
    begin
        logic [32:0]     sh;
        logic [31:0]     prem;
        logic [QW-1:0]   pq;
        logic [31:0]     dm;
        for (int s = 0; s < QW; s++)
        begin
            for (int a = 0; a < 3; a++)
            begin
                prem = (s == 0) ? 32'd0 : dv_rem_reg[(s == 0) ? 0 : s-1][a];
                pq   = (s == 0) ? '0 : dv_q_reg[(s == 0) ? 0 : s-1][a];
                dm   = (s == 0) ? in_item.ax[a].dmag
                                : dv_item_reg[(s == 0) ? 0 : s-1].ax[a].dmag;
                sh   = {prem, (s == 0)};
                if (sh >= {1'b0, dm})
                begin
                    dv_rem_next[s][a] = 32'(sh - {1'b0, dm});
                    dv_q_next[s][a]   = {pq[QW-2:0], 1'b1};
                end
                else
                begin
                    dv_rem_next[s][a] = 32'(sh);
                    dv_q_next[s][a]   = {pq[QW-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < QW; s++)
            begin
                dv_vld_reg[s] <= 1'b0;
            end
            mu_vld_reg  <= 1'b0;
            sl_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            dv_vld_reg[0] <= in_valid;
            for (int s = 1; s < QW; s++)
            begin
                dv_vld_reg[s] <= dv_vld_reg[s-1];
            end
            mu_vld_reg  <= dv_vld_reg[QW-1];
            sl_vld_reg  <= mu_vld_reg;
            out_vld_reg <= sl_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_item_reg[0] <= in_item;
            for (int s = 1; s < QW; s++)
            begin
                dv_item_reg[s] <= dv_item_reg[s-1];
            end
            for (int s = 0; s < QW; s++)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    dv_rem_reg[s][a] <= dv_rem_next[s][a];
                    dv_q_reg[s][a]   <= dv_q_next[s][a];
                end
            end
        end
    end

    // saturate reciprocal and scale the entry and exit distances
    always_comb
    begin
        logic [30:0]                        r;
        logic signed [rbst_pkg::DIFF_W-1:0] df;
        logic [32:0]                        mag;
        rbst_pkg::axis_t                    ax;
        for (int a = 0; a < 3; a++)
        begin
            ax = dv_item_reg[QW-1].ax[a];
            r  = (64'(dv_q_reg[QW-1][a]) > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF
                                                           : 31'(dv_q_reg[QW-1][a]);
            for (int k = 0; k < 2; k++)
            begin
                // k = 0 entry, k = 1 exit
                df  = ((k == 0) != ax.dneg) ? ax.lo : ax.hi;
                mag = df[rbst_pkg::DIFF_W-1] ? 33'(-df) : 33'(df);
                mu_neg_next[a][k]  = df[rbst_pkg::DIFF_W-1] ^ ax.dneg;
                mu_prod_next[a][k] = 64'(mag) * 64'(r);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < 3; a++)
            begin
                mu_prod_reg[a] <= mu_prod_next[a];
                mu_neg_reg[a]  <= mu_neg_next[a];
                mu_dz_reg[a]   <= dv_item_reg[QW-1].ax[a].dzero;
                mu_in_reg[a]   <= dv_item_reg[QW-1].ax[a].in_slab;
            end
        end
    end

    always_comb
    begin
        logic [63:0]        p;
        logic signed [31:0] t [2];
        for (int a = 0; a < 3; a++)
        begin
            for (int k = 0; k < 2; k++)
            begin
                p = mu_prod_reg[a][k] >> FRAC_BITS;
                if (mu_neg_reg[a][k])
                begin
                    t[k] = (p > 64'h8000_0000) ? rbst_pkg::SAT_MIN : 32'(~p + 64'd1);
                end
                else
                begin
                    t[k] = (p > 64'h7FFF_FFFF) ? rbst_pkg::SAT_MAX : 32'(p);
                end
            end
            if (mu_dz_reg[a])
            begin
                sl_en_next[a] = mu_in_reg[a] ? rbst_pkg::SAT_MIN : rbst_pkg::SAT_MAX;
                sl_ex_next[a] = mu_in_reg[a] ? rbst_pkg::SAT_MAX : rbst_pkg::SAT_MIN;
            end
            else
            begin
                sl_en_next[a] = t[0];
                sl_ex_next[a] = t[1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sl_en_reg <= sl_en_next;
            sl_ex_reg <= sl_ex_next;
        end
    end

    always_comb
    begin
        out_t0_next = sl_en_reg[0];
        out_t1_next = sl_ex_reg[0];
        for (int a = 1; a < 3; a++)
        begin
            if (sl_en_reg[a] > out_t0_next)
            begin
                out_t0_next = sl_en_reg[a];
            end
            if (sl_ex_reg[a] < out_t1_next)
            begin
                out_t1_next = sl_ex_reg[a];
            end
        end
        out_hit_next = (out_t0_next < out_t1_next)
                    && (out_t1_next > $signed(32'(HIT_EPSILON)));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_hit_reg <= out_hit_next;
            out_t0_reg  <= out_t0_next;
            out_t1_reg  <= out_t1_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {7'd0, out_t1_reg, out_t0_reg, out_hit_reg};

endmodule

### design/ray_box_slab_test_core.sv
// Top level of the ray versus axis-aligned box slab test core.
// A ray is registered in the queue, then the reciprocal stages, then the product, slab and result registers.
// Throughput: one ray per cycle while the output is not stalled; the reciprocal pipeline computes one bit per stage.
// A stalled output freezes the datapath; the two-entry queue keeps taking rays until full.
// Reset (rst_n, async, active low) empties queue and pipeline and zeroes the box registers.
`timescale 1ns / 1ps

module ray_box_slab_test_core
#(
    parameter int FRAC_BITS   = rbst_pkg::FRAC_BITS_DEF,
    parameter int HIT_EPSILON = rbst_pkg::HIT_EPSILON_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
    input  logic [191:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // hit, t_enter, t_exit, zero pad
    output logic [71:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    rbst_pkg::box_t  box_reg;
    rbst_pkg::item_t fr_item, q_item;
    logic            fr_push, q_full, q_valid, q_pop;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (rbst_pkg::cfg_reg_t'(cfg_index))
                rbst_pkg::REG_MIN_X: box_reg.mn[0]  <= cfg_data;
                rbst_pkg::REG_MIN_Y: box_reg.mn[1]  <= cfg_data;
                rbst_pkg::REG_MIN_Z: box_reg.mn[2]  <= cfg_data;
                rbst_pkg::REG_EXT_X: box_reg.ext[0] <= cfg_data[30:0];
                rbst_pkg::REG_EXT_Y: box_reg.ext[1] <= cfg_data[30:0];
                rbst_pkg::REG_EXT_Z: box_reg.ext[2] <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    rbst_front u_front
    (
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .box      (box_reg),
        .push     (fr_push),
        .item     (fr_item)
    );

    rbst_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (fr_push),
        .push_item  (fr_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_item  (q_item)
    );

    rbst_back
    #(
        .FRAC_BITS   (FRAC_BITS),
        .HIT_EPSILON (HIT_EPSILON)
    )
    u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (q_valid),
        .in_item  (q_item),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

### design/rbst_checker.sv
// Port-level checks for the ray/box slab test core, bound to the top level.
`timescale 1ns / 1ps
`include "ray_box_slab_test_core_macros.svh"

module rbst_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);

    `RBST_ASSERT_NXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `RBST_ASSERT_IMP(a_hit_order, clk, rst_n, m_tvalid && m_tdata[0], $signed(m_tdata[32:1]) < $signed(m_tdata[64:33]))
    `RBST_ASSERT_IMP(a_hit_ahead, clk, rst_n, m_tvalid && m_tdata[0], $signed(m_tdata[64:33]) > 0)
    `RBST_ASSERT_IMP(a_pad_zero, clk, rst_n, m_tvalid, m_tdata[71:65] == 7'd0)

endmodule

bind ray_box_slab_test_core rbst_checker u_rbst_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
